// File: design/fpa_pkg.sv
`default_nettype none

package fpa_pkg;

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_CMP      = 4'd4,
        OP_MIN      = 4'd5,
        OP_MAX      = 4'd6,
        OP_FROM_INT = 4'd7,
        OP_TO_INT   = 4'd8,
        OP_INC      = 4'd9,
        OP_DEC      = 4'd10
    } op_t;

    localparam int DATA_W = 32;
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);
    // Quotient bits resolved by each divider stage.
    localparam int DIV_STEPS = 2;

    // A request word after the front end has classified it.
    typedef struct packed {
        op_t               op;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic              lt;
        logic              eq;
        logic              gt;
    } item_t;

    // Side information carried alongside the divider stages.
    typedef struct packed {
        op_t               op;
        logic [DATA_W-1:0] res;
        logic              lt;
        logic              eq;
        logic              gt;
        logic              dz;
        logic              neg;
    } tag_t;

endpackage

`default_nettype wire

// File: design/fpa_front.sv
`default_nettype none

module fpa_front
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [3:0]                req_type,
    input  wire logic [fpa_pkg::DATA_W-1:0] operand_a,
    input  wire logic [fpa_pkg::DATA_W-1:0] operand_b,
    input  wire logic                      q_full,
    output logic                           push,
    output fpa_pkg::item_t                 item
);

    logic           valid_reg;
    logic           valid_next;
    fpa_pkg::item_t item_reg;
    fpa_pkg::item_t item_next;
    logic           accept;

    assign push   = valid_reg && !q_full;
    assign busy   = valid_reg && !push;
    assign accept = start && !busy;
    assign item   = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    // The compare flags hold for every operation, so they are resolved here.
    always_comb
    begin
        item_next.op = fpa_pkg::op_t'(req_type);
        item_next.a  = operand_a;
        item_next.b  = operand_b;
        item_next.lt = $signed(operand_a) <  $signed(operand_b);
        item_next.eq = operand_a == operand_b;
        item_next.gt = $signed(operand_a) >  $signed(operand_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

// File: design/fpa_queue.sv
`default_nettype none

module fpa_queue
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire fpa_pkg::item_t wr_item,
    output logic                full,
    output logic                rd_valid,
    output fpa_pkg::item_t      rd_item
);

    fpa_pkg::item_t                mem_reg [fpa_pkg::QDEPTH];
    logic [fpa_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [fpa_pkg::QPTR_W-1:0]    wr_ptr_next;
    logic [fpa_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [fpa_pkg::QPTR_W-1:0]    rd_ptr_next;
    logic [fpa_pkg::QCNT_W-1:0]    count_reg;
    logic [fpa_pkg::QCNT_W-1:0]    count_next;
    logic                          pop;

    assign full     = count_reg == fpa_pkg::QCNT_W'(fpa_pkg::QDEPTH);
    assign rd_valid = count_reg != '0;
    // The back end never stalls, so every stored word leaves in the next cycle.
    assign pop      = rd_valid;
    assign rd_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire

// File: design/fpa_back.sv
`default_nettype none

module fpa_back
#(
    parameter int FRAC_BITS = 8
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire fpa_pkg::item_t             in_item,
    output logic                            done,
    output logic [fpa_pkg::DATA_W-1:0]      result_raw,
    output logic                            is_less,
    output logic                            is_equal,
    output logic                            is_greater,
    output logic                            divide_by_zero
);

    localparam int DW   = fpa_pkg::DATA_W + FRAC_BITS;
    localparam int NSTG = (DW + fpa_pkg::DIV_STEPS - 1) / fpa_pkg::DIV_STEPS;
    localparam int W    = fpa_pkg::DATA_W;

    logic                  v_reg    [0:NSTG];
    fpa_pkg::tag_t         tag_reg  [0:NSTG];
    logic [DW-1:0]         num_reg  [0:NSTG];
    logic [W:0]            rem_reg  [0:NSTG];
    logic [W-1:0]          den_reg  [0:NSTG];
    logic [DW-1:0]         num_next [1:NSTG];
    logic [W:0]            rem_next [1:NSTG];
    fpa_pkg::tag_t         tag_next;

    logic                  done_reg;
    logic [W-1:0]          res_reg;
    logic                  lt_reg;
    logic                  eq_reg;
    logic                  gt_reg;
    logic                  dz_reg;
    logic [W-1:0]          res_next;

    logic signed [W-1:0]   sa;
    logic signed [W-1:0]   sb;
    logic signed [2*W-1:0] prod;
    logic [DW-1:0]         num_raw;
    logic [DW-1:0]         num_mag;
    logic [W-1:0]          den_mag;
    logic [W-1:0]          quo;

    // Setup stage: simple operations finish here, divide operands become magnitudes.
    always_comb
    begin
        sa       = $signed(in_item.a);
        sb       = $signed(in_item.b);
        prod     = sa * sb;
        num_raw  = {in_item.a, {FRAC_BITS{1'b0}}};
        num_mag  = in_item.a[W-1] ? (~num_raw + 1'b1) : num_raw;
        den_mag  = in_item.b[W-1] ? (~in_item.b + 1'b1) : in_item.b;

        tag_next.op  = in_item.op;
        tag_next.lt  = in_item.lt;
        tag_next.eq  = in_item.eq;
        tag_next.gt  = in_item.gt;
        tag_next.dz  = (in_item.op == fpa_pkg::OP_DIV) && (in_item.b == '0);
        tag_next.neg = in_item.a[W-1] ^ in_item.b[W-1];
        unique case (in_item.op)
            fpa_pkg::OP_ADD:      tag_next.res = in_item.a + in_item.b;
            fpa_pkg::OP_SUB:      tag_next.res = in_item.a - in_item.b;
            fpa_pkg::OP_MUL:      tag_next.res = prod[FRAC_BITS+W-1:FRAC_BITS];
            fpa_pkg::OP_MIN:      tag_next.res = in_item.lt ? in_item.a : in_item.b;
            fpa_pkg::OP_MAX:      tag_next.res = in_item.gt ? in_item.a : in_item.b;
            fpa_pkg::OP_FROM_INT: tag_next.res = in_item.a << FRAC_BITS;
            fpa_pkg::OP_TO_INT:   tag_next.res = W'(sa >>> FRAC_BITS);
            fpa_pkg::OP_INC:      tag_next.res = in_item.a + 1'b1;
            fpa_pkg::OP_DEC:      tag_next.res = in_item.a - 1'b1;
            default:              tag_next.res = '0;
        endcase
    end

    // Restoring divider: each stage shifts in dividend bits and sets quotient
    // bits into the vacated low end of the dividend register.
    always_comb
    begin
        logic [W:0]    r;
        logic [DW-1:0] n;
        for (int k = 1; k <= NSTG; k++)
        begin
            r = rem_reg[k-1];
            n = num_reg[k-1];
            for (int j = 0; j < fpa_pkg::DIV_STEPS; j++)
            begin
                if ((k - 1) * fpa_pkg::DIV_STEPS + j < DW)
                begin
                    r = {r[W-1:0], n[DW-1]};
                    n = {n[DW-2:0], 1'b0};
                    if (r >= {1'b0, den_reg[k-1]})
                    begin
                        r    = r - {1'b0, den_reg[k-1]};
                        n[0] = 1'b1;
                    end
                end
            end
            rem_next[k] = r;
            num_next[k] = n;
        end
    end

    always_comb
    begin
        quo = num_reg[NSTG][W-1:0];
        if (tag_reg[NSTG].op == fpa_pkg::OP_DIV)
        begin
            if (tag_reg[NSTG].dz)
            begin
                res_next = '0;
            end
            else
            begin
                res_next = tag_reg[NSTG].neg ? (~quo + 1'b1) : quo;
            end
        end
        else
        begin
            res_next = tag_reg[NSTG].res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NSTG; k++)
            begin
                v_reg[k] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k <= NSTG; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
            done_reg <= v_reg[NSTG];
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg[0] <= tag_next;
        num_reg[0] <= num_mag;
        rem_reg[0] <= '0;
        den_reg[0] <= den_mag;
        for (int k = 1; k <= NSTG; k++)
        begin
            tag_reg[k] <= tag_reg[k-1];
            num_reg[k] <= num_next[k];
            rem_reg[k] <= rem_next[k];
            den_reg[k] <= den_reg[k-1];
        end
        res_reg <= res_next;
        lt_reg  <= tag_reg[NSTG].lt;
        eq_reg  <= tag_reg[NSTG].eq;
        gt_reg  <= tag_reg[NSTG].gt;
        dz_reg  <= tag_reg[NSTG].dz;
    end

    assign done           = done_reg;
    assign result_raw     = res_reg;
    assign is_less        = lt_reg;
    assign is_equal       = eq_reg;
    assign is_greater     = gt_reg;
    assign divide_by_zero = dz_reg;

endmodule

`default_nettype wire

// File: design/fixed_point_q24_8_alu_unit.sv
// Channel   Handshake          Fields
// request   start / busy       req_type, operand_a, operand_b
// result    done (strobe)      result_raw, is_less, is_equal, is_greater, divide_by_zero
//
// One request word is taken in every cycle that busy is low; busy stays low in normal use.
// Every result passes the front-end register, the queue, the setup stage, the divider stages
// and the output register; the pipelined divider resolves two quotient bits a stage.
// All operations run through the same pipeline, so results leave in request order.
// Reset clears the valid bits and empties the queue; the data registers are not reset.
// The receiver cannot stall: done is a one-cycle strobe.
`default_nettype none

module fixed_point_q24_8_alu_unit
#(
    parameter int FRAC_BITS = 8
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [3:0]                        req_type,
    input  wire logic signed [fpa_pkg::DATA_W-1:0] operand_a,
    input  wire logic signed [fpa_pkg::DATA_W-1:0] operand_b,
    output logic                                   done,
    output logic signed [fpa_pkg::DATA_W-1:0]      result_raw,
    output logic                                   is_less,
    output logic                                   is_equal,
    output logic                                   is_greater,
    output logic                                   divide_by_zero
);

    logic                        push;
    logic                        q_full;
    logic                        q_valid;
    fpa_pkg::item_t              front_item;
    fpa_pkg::item_t              q_item;
    logic [fpa_pkg::DATA_W-1:0]  res;

    fpa_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req_type  (req_type),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .q_full    (q_full),
        .push      (push),
        .item      (front_item)
    );

    fpa_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_item  (front_item),
        .full     (q_full),
        .rd_valid (q_valid),
        .rd_item  (q_item)
    );

    fpa_back
    #(
        .FRAC_BITS (FRAC_BITS)
    )
    u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (q_valid),
        .in_item        (q_item),
        .done           (done),
        .result_raw     (res),
        .is_less        (is_less),
        .is_equal       (is_equal),
        .is_greater     (is_greater),
        .divide_by_zero (divide_by_zero)
    );

    assign result_raw = $signed(res);

endmodule

`default_nettype wire

// File: verif/tb.sv
`default_nettype none

class fixed_alu_scoreboard #(int FRAC_BITS = 8);

    typedef struct packed {
        logic [3:0]         op;
        logic signed [31:0] value;
        logic               lt;
        logic               eq;
        logic               gt;
        logic               dz;
    } alu_word_t;

    alu_word_t pending_results[$];
    int        errors;
    int        checked;
    int        zero_divisors;

    function new();
        errors        = 0;
        checked       = 0;
        zero_divisors = 0;
    endfunction

    function alu_word_t alu_outcome(input logic [3:0] op, input logic signed [31:0] a,
                                    input logic signed [31:0] b);
        alu_word_t w;
        longint    wide;
        w    = '0;
        w.op = op;
        w.lt = (a < b);
        w.eq = (a == b);
        w.gt = (a > b);
        case (op)
            fpa_pkg::OP_ADD: w.value = a + b;
            fpa_pkg::OP_SUB: w.value = a - b;
            fpa_pkg::OP_MUL:
            begin
                wide    = (longint'(a) * longint'(b)) >>> FRAC_BITS;
                w.value = wide[31:0];
            end
            fpa_pkg::OP_DIV:
            begin
                if (b == 0) begin
                    w.dz    = 1'b1;
                    w.value = '0;
                end
                else begin
                    // Truncating division of the scaled dividend; overflow wraps.
                    wide    = (longint'(a) <<< FRAC_BITS) / longint'(b);
                    w.value = wide[31:0];
                end
            end
            fpa_pkg::OP_CMP:      w.value = '0;
            fpa_pkg::OP_MIN:      w.value = w.lt ? a : b;
            fpa_pkg::OP_MAX:      w.value = w.gt ? a : b;
            fpa_pkg::OP_FROM_INT: w.value = a <<< FRAC_BITS;
            fpa_pkg::OP_TO_INT:   w.value = a >>> FRAC_BITS;
            fpa_pkg::OP_INC:      w.value = a + 32'sd1;
            fpa_pkg::OP_DEC:      w.value = a - 32'sd1;
            default:              w.value = '0;
        endcase
        return w;
    endfunction

    function int pending();
        return pending_results.size();
    endfunction

    function void note_request(input logic [3:0] op, input logic signed [31:0] a,
                               input logic signed [31:0] b);
        alu_word_t w;
        w = alu_outcome(op, a, b);
        if (w.dz)
            zero_divisors++;
        pending_results.push_back(w);
    endfunction

    task report(input string what, input logic [3:0] op, input logic [31:0] got,
                input logic [31:0] want);
        $display("tb: mismatch on %s (op %0d): got %h, expected %h", what, op, got, want);
        errors++;
    endtask

    task check_result(input logic signed [31:0] value, input logic lt, input logic eq,
                      input logic gt, input logic dz);
        alu_word_t want;
        if (pending_results.size() == 0) begin
            report("word with nothing outstanding", '0, value, '0);
            return;
        end
        want = pending_results.pop_front();
        checked++;
        if (value !== want.value)
            report("result_raw", want.op, value, want.value);
        if (lt !== want.lt)
            report("is_less", want.op, 32'(lt), 32'(want.lt));
        if (eq !== want.eq)
            report("is_equal", want.op, 32'(eq), 32'(want.eq));
        if (gt !== want.gt)
            report("is_greater", want.op, 32'(gt), 32'(want.gt));
        if (dz !== want.dz)
            report("divide_by_zero", want.op, 32'(dz), 32'(want.dz));
    endtask

endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS    = 8;
    localparam int PIPE_DELAY   = 24;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_WORDS = 1400;
    localparam int PHASES       = 5;

    localparam logic signed [31:0] MAX_RAW = 32'h7fff_ffff;
    localparam logic signed [31:0] MIN_RAW = 32'h8000_0000;
    localparam logic [3:0]         OP_SPARE_LO = 4'd11;
    localparam logic [3:0]         OP_SPARE_HI = 4'd15;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [3:0]         req_type;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic               done;
    logic signed [31:0] result_raw;
    logic               is_less;
    logic               is_equal;
    logic               is_greater;
    logic               divide_by_zero;

    fixed_alu_scoreboard #(FRAC_BITS) sb;

    int idle_pct;
    int stall_cycles;
    int words_sent;
    int spare_sent;
    int idle_plan [PHASES] = '{0, 62, 17, 0, 62};

    fixed_point_q24_8_alu_unit #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req_type(req_type),
        .operand_a(operand_a),
        .operand_b(operand_b),
        .done(done),
        .result_raw(result_raw),
        .is_less(is_less),
        .is_equal(is_equal),
        .is_greater(is_greater),
        .divide_by_zero(divide_by_zero)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Results are checked before the request of the same edge is noted; a result can
    // never belong to a word accepted at that very edge.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result_raw, is_less, is_equal, is_greater, divide_by_zero);
        if (rst_n && start && !busy)
            sb.note_request(req_type, operand_a, operand_b);

        if (!rst_n || (start && !busy) || done) begin
            stall_cycles <= 0;
        end
        else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles + 1 >= STALL_LIMIT) begin
                $display("tb: no progress for %0d cycles", STALL_LIMIT);
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    task send_word(input logic [3:0] op, input logic signed [31:0] a,
                   input logic signed [31:0] b);
        while ($urandom_range(99) < idle_pct) begin
            start     <= 1'b0;
            operand_a <= $urandom;
            operand_b <= $urandom;
            @(posedge clk);
        end
        start     <= 1'b1;
        req_type  <= op;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        words_sent++;
        if (op >= OP_SPARE_LO)
            spare_sent++;
    endtask

    task wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [31:0] pick_operand();
        case ($urandom_range(9))
            0:       return MAX_RAW;
            1:       return MIN_RAW;
            2:       return int'($urandom_range(1023)) - 512;
            3:       return (int'($urandom_range(2047)) - 1024) <<< FRAC_BITS;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [3:0] pick_op();
        if ($urandom_range(99) < 4)
            return 4'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
        return 4'($urandom_range(fpa_pkg::OP_DEC, fpa_pkg::OP_ADD));
    endfunction

    task send_random();
        logic [3:0]         op;
        logic signed [31:0] a;
        logic signed [31:0] b;
        op = pick_op();
        a  = pick_operand();
        b  = pick_operand();
        if ($urandom_range(9) == 0)
            b = a;
        if (op == fpa_pkg::OP_DIV && $urandom_range(9) == 0)
            b = '0;
        send_word(op, a, b);
    endtask

    initial
    begin
        sb         = new();
        rst_n      = 1'b0;
        start      = 1'b0;
        req_type   = fpa_pkg::OP_ADD;
        operand_a  = '0;
        operand_b  = '0;
        idle_pct   = 0;
        words_sent = 0;
        spare_sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every operation on the most negative value against minus one.
        for (int op = fpa_pkg::OP_ADD; op <= fpa_pkg::OP_DEC; op++)
            send_word(4'(op), MIN_RAW, -32'sd1);
        send_word(fpa_pkg::OP_DIV, 32'sd5, 32'sd0);
        send_word(fpa_pkg::OP_DIV, MAX_RAW, 32'sd1);
        send_word(fpa_pkg::OP_CMP, 32'sd7, 32'sd7);
        send_word(fpa_pkg::OP_CMP, MAX_RAW, MIN_RAW);
        send_word(fpa_pkg::OP_MUL, MIN_RAW, MIN_RAW);
        send_word(fpa_pkg::OP_MUL, MAX_RAW, MAX_RAW);
        send_word(fpa_pkg::OP_MIN, 32'sd3, 32'sd3);
        send_word(fpa_pkg::OP_MAX, MIN_RAW, MAX_RAW);
        send_word(fpa_pkg::OP_FROM_INT, MAX_RAW, 32'sd0);
        send_word(fpa_pkg::OP_TO_INT, -32'sd1, 32'sd0);
        send_word(fpa_pkg::OP_INC, MAX_RAW, MAX_RAW);
        send_word(OP_SPARE_LO, 32'sd1, 32'sd2);
        send_word(OP_SPARE_HI, MAX_RAW, MAX_RAW);
        wait_drained();

        // The drain between phases keeps the sender quiet until all words are back.
        for (int p = 0; p < PHASES; p++) begin
            idle_pct = idle_plan[p];
            repeat (RANDOM_WORDS / PHASES)
                send_random();
            wait_drained();
        end

        repeat (PIPE_DELAY + 8) @(posedge clk);
        $display("tb: %0d words sent, %0d results checked, %0d with a zero divisor",
                 words_sent, sb.checked, sb.zero_divisors);
        $display("tb: %0d spare opcodes; sender idle at 0, 17 and 62 percent", spare_sent);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
